>>> rtl/bounded_osa_edit_distance_assert.svh
// Assertion macros for the edit distance block. Each takes a label, a clock, an
// active-low reset, an antecedent and a consequent.
`ifndef BOUNDED_OSA_EDIT_DISTANCE_ASSERT_SVH
`define BOUNDED_OSA_EDIT_DISTANCE_ASSERT_SVH

`ifndef SYNTHESIS

`define BOSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bosa assertion failed");

`define BOSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bosa assertion failed");

`else

`define BOSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define BOSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/bosa_pkg.sv
`default_nettype none

package bosa_pkg;

    typedef enum logic [1:0] {
        OP_SRC     = 2'd0,
        OP_TGT     = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 7;
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;

    // Word index of the threshold register.
    localparam logic REG_MAX_DIST = 1'b0;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 7'd64;
    localparam logic [DIST_W-1:0] DIST_SAT       = 7'd127;

endpackage

`default_nettype wire

>>> rtl/bounded_osa_edit_distance.sv
// Load items (append source, append target, clear) keep busy low.
// A compute item walks one row per source byte, one cell per cycle through the row
// memory, each row through the row-read, source, column (if any) and end states;
// the strobe follows the last row, earlier on an early stop, next cycle for an
// empty source. The receiver cannot stall; each result is a one-cycle strobe.
// Synchronous reset empties both strings, clears the overflow flag, threshold to 64.
`default_nettype none

`include "bounded_osa_edit_distance_assert.svh"

module bounded_osa_edit_distance #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           i_operation,
    input  wire logic [bosa_pkg::CHAR_W-1:0]          i_char_code,
    output logic                                      o_valid,
    output logic [bosa_pkg::DIST_W-1:0]               o_distance,
    output logic                                      o_matched,
    output logic                                      o_too_long,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bosa_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [bosa_pkg::DATA_W-1:0]          pwdata,
    output logic [bosa_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int VAL_W = LEN_W + 1;
    localparam int RES_W = (LEN_W > 8) ? LEN_W : 8;
    localparam int CD    = 2 * MAX_LEN;
    localparam int CAW   = $clog2(CD);
    localparam int RD    = 3 * (MAX_LEN + 1);
    localparam int RAW   = $clog2(RD);

    localparam logic [CAW-1:0]   TGT_BASE = CAW'(MAX_LEN);
    localparam logic [RAW-1:0]   BANK1    = RAW'(MAX_LEN + 1);
    localparam logic [RAW-1:0]   BANK2    = RAW'(2 * (MAX_LEN + 1));
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROWRD,
        S_SRC,
        S_COL,
        S_END
    } t_state;

    // Storage: source and target bytes share one memory, the three kept rows
    // share another, each row a bank whose role rotates after every row.
    logic [bosa_pkg::CHAR_W-1:0] char_mem [CD];
    logic [LEN_W-1:0]            row_mem  [RD];

    t_state                      r_state;
    logic [LEN_W-1:0]            r_slen;
    logic [LEN_W-1:0]            r_tlen;
    logic                        r_overflow;
    logic [bosa_pkg::DIST_W-1:0] r_max_dist;
    logic                        r_valid;
    logic [bosa_pkg::DIST_W-1:0] r_distance;
    logic                        r_matched;
    logic                        r_too_long;

    logic [LEN_W-1:0]            r_row;
    logic [LEN_W-1:0]            r_ci;
    logic [LEN_W-1:0]            r_pc;
    logic                        r_pv;
    logic [RAW-1:0]              r_base_cur;
    logic [RAW-1:0]              r_base_prev;
    logic [RAW-1:0]              r_base_pp;
    logic [bosa_pkg::CHAR_W-1:0] r_sc;
    logic [bosa_pkg::CHAR_W-1:0] r_sc_prev;
    logic [bosa_pkg::CHAR_W-1:0] r_tc_prev;
    logic [LEN_W-1:0]            r_cur_left;
    logic [LEN_W-1:0]            r_prev_left;
    logic [LEN_W-1:0]            r_row_min;
    logic [LEN_W-1:0]            r_last;

    logic [bosa_pkg::CHAR_W-1:0] r_char_rd;
    logic [LEN_W-1:0]            r_rowa_rd;
    logic [LEN_W-1:0]            r_rowb_rd;

    logic                        accept;
    logic                        cfg_wr;
    logic                        char_we;
    logic [CAW-1:0]              char_waddr;
    logic [CAW-1:0]              char_raddr;
    logic [RAW-1:0]              rowa_addr;
    logic [RAW-1:0]              rowb_addr;
    logic                        row_we;
    logic [RAW-1:0]              row_waddr;
    logic [LEN_W-1:0]            row_wdata;
    logic                        issue;
    logic                        bounded;
    logic                        early_stop;

    logic [VAL_W-1:0]            n_pv;
    logic [VAL_W-1:0]            n_bb;
    logic [VAL_W-1:0]            n_best;
    logic [LEN_W-1:0]            n_cell;
    logic                        n_emit;
    logic [RES_W-1:0]            n_dist;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_valid;
    assign o_distance = r_distance;
    assign o_matched  = r_matched;
    assign o_too_long = r_too_long;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == bosa_pkg::REG_MAX_DIST)
                   ? {{(bosa_pkg::DATA_W - bosa_pkg::DIST_W){1'b0}}, r_max_dist}
                   : '0;

    assign bounded    = (32'(r_max_dist) < MAX_LEN);
    assign early_stop = bounded && (32'(r_row_min) > 32'(r_max_dist));
    assign issue      = (r_state == S_COL) && (r_ci <= r_tlen);

    // Load writes into the byte memory.
    always_comb begin
        char_we    = 1'b0;
        char_waddr = CAW'(r_slen);
        if (accept) begin
            if (i_operation == bosa_pkg::OP_SRC) begin
                char_we = (r_slen < LEN_FULL);
            end else if (i_operation == bosa_pkg::OP_TGT) begin
                char_we    = (r_tlen < LEN_FULL);
                char_waddr = TGT_BASE + CAW'(r_tlen);
            end
        end
    end

    // Read addresses: the source byte at row start, then one target byte and two
    // row entries for each column issued.
    always_comb begin
        char_raddr = '0;
        case (r_state)
            S_ROWRD: char_raddr = CAW'(r_row - LEN_W'(1));
            S_COL:   char_raddr = TGT_BASE + CAW'(r_ci - LEN_W'(1));
            default: char_raddr = '0;
        endcase
        rowa_addr = r_base_prev + RAW'(r_ci);
        rowb_addr = (r_ci >= LEN_W'(2)) ? r_base_pp + RAW'(r_ci - LEN_W'(2)) : r_base_pp;
    end

    // Cell update. Row one sees the initial row 0..tlen, and row two sees it as the
    // row before the previous one, so those reads are replaced by the column index.
    always_comb begin
        n_pv = (r_row == LEN_W'(1)) ? VAL_W'(r_pc) : VAL_W'(r_rowa_rd);
        n_bb = (r_row == LEN_W'(2)) ? VAL_W'(r_pc - LEN_W'(2)) : VAL_W'(r_rowb_rd);
        n_best = n_pv + VAL_W'(1);
        if (VAL_W'(r_cur_left) + VAL_W'(1) < n_best) begin
            n_best = VAL_W'(r_cur_left) + VAL_W'(1);
        end
        if (VAL_W'(r_prev_left) + VAL_W'(r_sc != r_char_rd) < n_best) begin
            n_best = VAL_W'(r_prev_left) + VAL_W'(r_sc != r_char_rd);
        end
        if ((r_row > LEN_W'(1)) && (r_pc > LEN_W'(1)) && (r_sc == r_tc_prev)
                && (r_sc_prev == r_char_rd) && (n_bb + VAL_W'(1) < n_best)) begin
            n_best = n_bb + VAL_W'(1);
        end
        n_cell = n_best[LEN_W-1:0];
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_base_cur;
        row_wdata = r_row;
        if (r_state == S_ROWRD) begin
            row_we = 1'b1;
        end else if (r_state == S_COL && r_pv) begin
            row_we    = 1'b1;
            row_waddr = r_base_cur + RAW'(r_pc);
            row_wdata = n_cell;
        end
    end

    always_comb begin
        n_emit = 1'b0;
        n_dist = RES_W'(r_last);
        if (accept && i_operation == bosa_pkg::OP_COMPUTE && r_slen == '0) begin
            n_emit = 1'b1;
            n_dist = RES_W'(r_tlen);
        end else if (r_state == S_END) begin
            if (early_stop) begin
                n_emit = 1'b1;
                n_dist = RES_W'(r_max_dist) + RES_W'(1);
            end else if (r_row == r_slen) begin
                n_emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (char_we) begin
            char_mem[char_waddr] <= i_char_code;
        end
        r_char_rd <= char_mem[char_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        r_rowa_rd <= row_mem[rowa_addr];
        r_rowb_rd <= row_mem[rowb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slen     <= '0;
            r_tlen     <= '0;
            r_overflow <= 1'b0;
            r_max_dist <= bosa_pkg::MAX_DIST_RESET;
            r_valid    <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            r_valid <= n_emit;
            if (n_emit) begin
                r_distance <= (n_dist > RES_W'(bosa_pkg::DIST_SAT))
                            ? bosa_pkg::DIST_SAT : n_dist[bosa_pkg::DIST_W-1:0];
                r_matched  <= (n_dist <= RES_W'(r_max_dist));
                r_too_long <= r_overflow;
                r_tlen     <= '0;
            end
            if (cfg_wr && paddr[2] == bosa_pkg::REG_MAX_DIST) begin
                r_max_dist <= pwdata[bosa_pkg::DIST_W-1:0];
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (bosa_pkg::t_op'(i_operation))
                            bosa_pkg::OP_SRC: begin
                                if (r_slen < LEN_FULL) begin
                                    r_slen <= r_slen + LEN_W'(1);
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            bosa_pkg::OP_TGT: begin
                                if (r_tlen < LEN_FULL) begin
                                    r_tlen <= r_tlen + LEN_W'(1);
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            bosa_pkg::OP_COMPUTE: begin
                                r_row       <= LEN_W'(1);
                                r_base_cur  <= '0;
                                r_base_prev <= BANK1;
                                r_base_pp   <= BANK2;
                                if (r_slen != '0) begin
                                    r_state <= S_ROWRD;
                                end
                            end
                            bosa_pkg::OP_CLEAR: begin
                                r_slen     <= '0;
                                r_tlen     <= '0;
                                r_overflow <= 1'b0;
                            end
                            default: begin
                                r_overflow <= r_overflow;
                            end
                        endcase
                    end
                end
                S_ROWRD: begin
                    r_cur_left  <= r_row;
                    r_prev_left <= r_row - LEN_W'(1);
                    r_row_min   <= r_row;
                    r_last      <= r_row;
                    r_ci        <= LEN_W'(1);
                    r_pv        <= 1'b0;
                    r_state     <= S_SRC;
                end
                S_SRC: begin
                    r_sc      <= r_char_rd;
                    r_sc_prev <= r_sc;
                    r_state   <= (r_tlen == '0) ? S_END : S_COL;
                end
                S_COL: begin
                    r_pv <= issue;
                    if (issue) begin
                        r_pc <= r_ci;
                        r_ci <= r_ci + LEN_W'(1);
                    end
                    if (r_pv) begin
                        r_cur_left  <= n_cell;
                        r_prev_left <= n_pv[LEN_W-1:0];
                        r_tc_prev   <= r_char_rd;
                        if (n_cell < r_row_min) begin
                            r_row_min <= n_cell;
                        end
                        if (r_pc == r_tlen) begin
                            r_last  <= n_cell;
                            r_state <= S_END;
                        end
                    end
                end
                S_END: begin
                    r_pv <= 1'b0;
                    if (n_emit) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_row       <= r_row + LEN_W'(1);
                        r_base_cur  <= r_base_pp;
                        r_base_prev <= r_base_cur;
                        r_base_pp   <= r_base_prev;
                        r_state     <= S_ROWRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result always leaves the block idle with the target emptied.
    `BOSA_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy && r_tlen == '0)
    // The three row banks never alias, so a cell write cannot hit a row being read.
    `BOSA_ASSERT_SAME(a_banks_apart, i_clk, i_rst_n, busy,
        r_base_cur != r_base_prev && r_base_cur != r_base_pp && r_base_prev != r_base_pp)
    // A cell in flight always lies within the target columns.
    `BOSA_ASSERT_SAME(a_col_range, i_clk, i_rst_n, r_state == S_COL && r_pv,
        r_pc != '0 && r_pc <= r_tlen)
    // After a row ends without a result, the next row starts one higher.
    `BOSA_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, r_state == S_END && !n_emit,
        r_state == S_ROWRD && r_row == $past(r_row) + LEN_W'(1))

endmodule

`default_nettype wire

>>> sim/bounded_osa_edit_distance_checker.sv
`default_nettype none

module bounded_osa_edit_distance_checker
    import bosa_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire logic [1:0]          i_operation,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic                i_valid,
    input  wire logic [DIST_W-1:0]   i_distance,
    input  wire logic                i_matched,
    input  wire logic                i_too_long,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic                i_pready,
    input  wire logic [PADDR_W-1:0]  i_paddr,
    input  wire logic [DATA_W-1:0]   i_pwdata,
    output int                       o_error_count,
    output int                       o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] THRESH_ADDR = PADDR_W'(REG_MAX_DIST) << 2;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              matched;
        logic              too_long;
    } t_osa_result;

    logic [CHAR_W-1:0] src_bytes [MAX_LEN];
    logic [CHAR_W-1:0] tgt_bytes [MAX_LEN];
    int                src_len;
    int                tgt_len;
    logic              truncated;
    logic [DIST_W-1:0] threshold;
    t_osa_result       expected_distances[$];
    int                mismatch_count = 0;
    int                outstanding = 0;

    assign o_error_count   = mismatch_count;
    assign o_pending_count = outstanding;

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // Three rolling rows; a row whose minimum passes a bounded threshold stops early.
    function automatic int osa_distance();
        int  two_back [MAX_LEN+1];
        int  one_back [MAX_LEN+1];
        int  cur_row [MAX_LEN+1];
        int  row_min;
        int  best;
        int  cost;
        bit  bounded;
        bounded = int'(threshold) < MAX_LEN;
        for (int c = 0; c <= tgt_len; c++) begin
            two_back[c] = 0;
            one_back[c] = c;
            cur_row[c]  = 0;
        end
        for (int r = 1; r <= src_len; r++) begin
            row_min    = r;
            cur_row[0] = r;
            for (int c = 1; c <= tgt_len; c++) begin
                cost = (src_bytes[r-1] == tgt_bytes[c-1]) ? 0 : 1;
                best = min_of(one_back[c] + 1, cur_row[c-1] + 1);
                best = min_of(best, one_back[c-1] + cost);
                if (r > 1 && c > 1 && src_bytes[r-1] == tgt_bytes[c-2] &&
                    src_bytes[r-2] == tgt_bytes[c-1]) begin
                    best = min_of(best, two_back[c-2] + 1);
                end
                cur_row[c] = best;
                row_min    = min_of(row_min, best);
            end
            if (bounded && row_min > int'(threshold)) begin
                return int'(threshold) + 1;
            end
            two_back = one_back;
            one_back = cur_row;
        end
        return one_back[tgt_len];
    endfunction

    always @(posedge i_clk) begin
        t_osa_result got;
        t_osa_result want;
        int          full_span;
        if (!i_rst_n) begin
            src_len   = 0;
            tgt_len   = 0;
            truncated = 1'b0;
            threshold = MAX_DIST_RESET;
            expected_distances.delete();
        end else begin
            if (i_valid) begin
                got = {i_distance, i_matched, i_too_long};
                if (expected_distances.size() == 0) begin
                    $error("result with no compute waiting: distance %0d", i_distance);
                    mismatch_count++;
                end else begin
                    want = expected_distances.pop_front();
                    if (got.distance !== want.distance) begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want.distance, got.distance);
                        mismatch_count++;
                    end
                    if (got.matched !== want.matched) begin
                        $error("matched mismatch: expected %0b, actual %0b",
                               want.matched, got.matched);
                        mismatch_count++;
                    end
                    if (got.too_long !== want.too_long) begin
                        $error("too_long mismatch: expected %0b, actual %0b",
                               want.too_long, got.too_long);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (t_op'(i_operation))
                    OP_SRC: begin
                        if (src_len < MAX_LEN) begin
                            src_bytes[src_len] = i_char_code;
                            src_len++;
                        end else begin
                            truncated = 1'b1;
                        end
                    end
                    OP_TGT: begin
                        if (tgt_len < MAX_LEN) begin
                            tgt_bytes[tgt_len] = i_char_code;
                            tgt_len++;
                        end else begin
                            truncated = 1'b1;
                        end
                    end
                    OP_COMPUTE: begin
                        full_span = osa_distance();
                        want.distance = (full_span > int'(DIST_SAT))
                                      ? DIST_SAT : DIST_W'(full_span);
                        want.matched  = (full_span <= int'(threshold));
                        want.too_long = truncated;
                        expected_distances = {expected_distances, want};
                        tgt_len = 0;
                    end
                    default: begin
                        // Clear drops both strings and forgets any earlier truncation.
                        src_len   = 0;
                        tgt_len   = 0;
                        truncated = 1'b0;
                    end
                endcase
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == THRESH_ADDR) begin
                threshold = i_pwdata[DIST_W-1:0];
            end
        end
        outstanding = expected_distances.size();
    end

endmodule

`default_nettype wire

>>> sim/bounded_osa_edit_distance_tb.sv
`default_nettype none

module bounded_osa_edit_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bosa_pkg::*;

    localparam int LEN_MAX      = 64;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CFG_EVERY    = 150;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam logic [PADDR_W-1:0] THRESH_ADDR = PADDR_W'(REG_MAX_DIST) << 2;

    typedef logic [CHAR_W-1:0] t_char;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_operation;
    t_char               i_char_code;
    logic                o_valid;
    logic [DIST_W-1:0]   o_distance;
    logic                o_matched;
    logic                o_too_long;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int    error_count;
    int    pending_count;
    int    cycle_count = 0;
    int    items_sent = 0;
    bit    steady = 1'b0;
    t_char source_text[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[bounded_osa_edit_distance] ERROR");
            $finish;
        end
    end

    bounded_osa_edit_distance #(
        .MAX_LEN(LEN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .o_distance  (o_distance),
        .o_matched   (o_matched),
        .o_too_long  (o_too_long),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bounded_osa_edit_distance_checker #(
        .MAX_LEN(LEN_MAX)
    ) osa_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_valid         (o_valid),
        .i_distance      (o_distance),
        .i_matched       (o_matched),
        .i_too_long      (o_too_long),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(t_op op, t_char ch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_char_code <= ch;
        do @(posedge i_clk); while (busy);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Loads cause no result, so a few spare cycles follow the last result.
    task automatic settle();
        start <= 1'b0;
        while (pending_count != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_threshold(int value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A small alphabet gives matches and adjacent swaps often.
    function automatic t_char pick_byte(bit narrow);
        if (narrow) begin
            return t_char'(8'h61 + $urandom_range(0, 3));
        end
        return t_char'($urandom_range(0, 255));
    endfunction

    // Mostly short strings, some medium, a few that run past the buffer.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            return $urandom_range(0, 12);
        end else if (roll < 95) begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(60, 70);
    endfunction

    task automatic derive_target(bit narrow, output t_char tq[$]);
        int    pos;
        t_char held;
        tq = source_text;
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0: begin
                    if (tq.size() > 0) begin
                        tq[$urandom_range(0, tq.size() - 1)] = pick_byte(narrow);
                    end
                end
                1: tq.insert($urandom_range(0, tq.size()), pick_byte(narrow));
                2: begin
                    if (tq.size() > 0) begin
                        tq.delete($urandom_range(0, tq.size() - 1));
                    end
                end
                default: begin
                    if (tq.size() > 1) begin
                        pos         = $urandom_range(0, tq.size() - 2);
                        held        = tq[pos];
                        tq[pos]     = tq[pos + 1];
                        tq[pos + 1] = held;
                    end
                end
            endcase
        end
    endtask

    task automatic compare_candidate(bit narrow);
        t_char tq[$];
        int    len;
        if ($urandom_range(0, 9) < 7) begin
            derive_target(narrow, tq);
        end else begin
            len = pick_length();
            repeat (len) tq = {tq, pick_byte(narrow)};
        end
        foreach (tq[i]) send_item(OP_TGT, tq[i]);
        send_item(OP_COMPUTE, pick_byte(1'b0));
    endtask

    task automatic random_sequence();
        int  roll;
        int  len;
        bit  narrow;
        roll   = $urandom_range(0, 99);
        narrow = $urandom_range(0, 2) != 0;
        steady = $urandom_range(0, 3) == 0;
        if (roll < 8) begin
            // Noise: any operation with any byte.
            repeat ($urandom_range(1, 3)) begin
                send_item(t_op'($urandom_range(0, 3)), pick_byte(1'b0));
            end
            source_text.delete();
        end else begin
            if (source_text.size() == 0 || roll < 45) begin
                send_item(OP_CLEAR, pick_byte(1'b0));
                source_text.delete();
                len = pick_length();
                repeat (len) source_text = {source_text, pick_byte(narrow)};
                foreach (source_text[i]) send_item(OP_SRC, source_text[i]);
            end else if (roll < 55) begin
                repeat ($urandom_range(1, 3)) begin
                    source_text = {source_text, pick_byte(narrow)};
                    send_item(OP_SRC, source_text[source_text.size() - 1]);
                end
            end
            repeat ($urandom_range(1, 3)) compare_candidate(narrow);
        end
    endtask

    function automatic int next_threshold(int phase);
        int plan [7] = '{64, 2, 0, 5, 63, 1, 3};
        if (phase < 7) begin
            return plan[phase];
        end
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 64);
        end
        return $urandom_range(0, 6);
    endfunction

    initial begin
        int base;
        int cfg_mark;
        int cfg_phase;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = OP_SRC;
        i_char_code = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Threshold at reset is unbounded.
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_TGT, 8'h61);
        send_item(OP_TGT, 8'h62);
        send_item(OP_COMPUTE, 8'hFF);
        send_item(OP_SRC, 8'h61);
        send_item(OP_SRC, 8'h62);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_TGT, 8'h62);
        send_item(OP_TGT, 8'h61);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_TGT, 8'h00);
        send_item(OP_TGT, 8'hFF);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_CLEAR, 8'hFF);

        // Zero threshold: any difference stops on the first row.
        write_threshold(0);
        send_item(OP_SRC, 8'hFF);
        send_item(OP_TGT, 8'h00);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_TGT, 8'hFF);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_COMPUTE, 8'h00);

        // Empty target stops once the row number passes the threshold.
        write_threshold(1);
        send_item(OP_SRC, 8'h00);
        send_item(OP_COMPUTE, 8'hFF);
        send_item(OP_TGT, 8'h00);
        send_item(OP_TGT, 8'hFF);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_CLEAR, 8'h00);

        base      = items_sent;
        cfg_mark  = items_sent;
        cfg_phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (cfg_phase == 0 || items_sent - cfg_mark >= CFG_EVERY) begin
                write_threshold(next_threshold(cfg_phase));
                cfg_phase++;
                cfg_mark = items_sent;
            end
            random_sequence();
        end

        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("[bounded_osa_edit_distance] OK");
        end else begin
            $display("[bounded_osa_edit_distance] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
